FILE: rtl/assert_macros.svh
// Assertion macros of the checker file of the gate timer.
// Included by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TPCGT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gate timer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TPCGT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gate timer assertion failed");

`endif

FILE: rtl/tpcgt_pkg.sv
// Package of the triac phase-cut gate timer: widths, defaults, register codes, types.
// No dependencies; the interfaces, top level, register file and engine import it.
`timescale 1ns / 1ps

package tpcgt_pkg;

   localparam int CFG_W      = 16;
   localparam int IDX_W      = 3;
   localparam int US_W       = 32;
   localparam int COUNT_W    = 20;
   localparam int PRESCALE_W = 3;
   localparam int BASE_W     = 24;

   localparam int DEF_US_TICKS      = 5;
   localparam int DEF_PULSE_US      = 50;
   localparam int DEF_ZC_OFFSET_US  = 16;

   localparam logic [CFG_W-1:0] RST_HALF_CYCLE_US = 16'd10000;
   localparam logic [CFG_W-1:0] RST_MIN_CUT_US    = 16'd2500;
   localparam logic [CFG_W-1:0] RST_MAX_CUT_US    = 16'd7500;
   localparam logic [CFG_W-1:0] RST_ZC_HOLDOFF_US = 16'd9919;
   localparam logic [CFG_W-1:0] RST_CUT_DELAY_US  = 16'd7500;

   typedef enum logic [IDX_W-1:0] {
      REG_HALF_CYCLE = 3'd0,
      REG_MIN_CUT    = 3'd1,
      REG_MAX_CUT    = 3'd2,
      REG_HOLDOFF    = 3'd3,
      REG_CUT_DELAY  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] half_cycle_us;
      logic [CFG_W-1:0] min_cut_us;
      logic [CFG_W-1:0] max_cut_us;
      logic [CFG_W-1:0] zc_holdoff_us;
      logic [CFG_W-1:0] cut_delay_us;
   } cfg_type;

   typedef struct packed {
      logic gate_on;
      logic zc_accepted;
   } result_type;

endpackage

FILE: rtl/tpcgt_ifs.sv
// Channel interfaces of the gate timer: tick requests, results, register writes.
// Depends on tpcgt_pkg.
`timescale 1ns / 1ps

interface tpcgt_req_if;
   logic valid;
   logic ready;
   logic zc_edge;
   modport source (output valid, output zc_edge, input ready);
   modport sink   (input valid, input zc_edge, output ready);
endinterface

interface tpcgt_rsp_if;
   logic valid;
   logic ready;
   logic gate_on;
   logic zc_accepted;
   modport source (output valid, output gate_on, output zc_accepted, input ready);
   modport sink   (input valid, input gate_on, input zc_accepted, output ready);
endinterface

interface tpcgt_csr_if;
   import tpcgt_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [CFG_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/triac_phase_cut_gate_timer_top.sv
// Triac phase-cut gate timer, top level. A tick word is accepted into an input
// register and its result word lands in the output register when the engine
// steps; a full output register that the sink does not take holds the step.
// One word per cycle sustained while the sink takes results, set by the
// single engine step between the two registers.
// Synchronous active-high reset clears pipeline and timing state, loads register defaults.
`timescale 1ns / 1ps

module triac_phase_cut_gate_timer_top #(
   parameter int TICKS_PER_MICROSECOND          = tpcgt_pkg::DEF_US_TICKS,
   parameter int GATE_PULSE_MICROSECONDS        = tpcgt_pkg::DEF_PULSE_US,
   parameter int ZERO_CROSS_OFFSET_MICROSECONDS = tpcgt_pkg::DEF_ZC_OFFSET_US
) (
   input  logic      clock,
   input  logic      reset,
   tpcgt_req_if.sink req_chan,
   tpcgt_rsp_if.source rsp_chan,
   tpcgt_csr_if.sink csr_chan
);
   import tpcgt_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       in_edge_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       advance;

   // Register writes are always taken
   assign csr_chan.ready = 1'b1;

   tpcgt_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   // Step the engine when the held word can move to the output register
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   tpcgt_engine #(
      .TICKS_PER_MICROSECOND          (TICKS_PER_MICROSECOND),
      .GATE_PULSE_MICROSECONDS        (GATE_PULSE_MICROSECONDS),
      .ZERO_CROSS_OFFSET_MICROSECONDS (ZERO_CROSS_OFFSET_MICROSECONDS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .zc_edge (in_edge_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Hold or refill the input and output registers
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_edge_ff <= req_chan.zc_edge;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.gate_on     = out_ff.gate_on;
   assign rsp_chan.zc_accepted = out_ff.zc_accepted;

endmodule

FILE: rtl/tpcgt_regs.sv
// Configuration register file of the gate timer.
// Depends on tpcgt_pkg.
`timescale 1ns / 1ps

module tpcgt_regs (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [tpcgt_pkg::IDX_W-1:0] wr_index,
   input  logic [tpcgt_pkg::CFG_W-1:0] wr_data,
   output tpcgt_pkg::cfg_type          cfg
);
   import tpcgt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; unknown indexes leave the file as it is
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index_type'(wr_index))
            REG_HALF_CYCLE: cfg_in.half_cycle_us = wr_data;
            REG_MIN_CUT:    cfg_in.min_cut_us    = wr_data;
            REG_MAX_CUT:    cfg_in.max_cut_us    = wr_data;
            REG_HOLDOFF:    cfg_in.zc_holdoff_us = wr_data;
            REG_CUT_DELAY:  cfg_in.cut_delay_us  = wr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_cycle_us <= RST_HALF_CYCLE_US;
         cfg_ff.min_cut_us    <= RST_MIN_CUT_US;
         cfg_ff.max_cut_us    <= RST_MAX_CUT_US;
         cfg_ff.zc_holdoff_us <= RST_ZC_HOLDOFF_US;
         cfg_ff.cut_delay_us  <= RST_CUT_DELAY_US;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/tpcgt_engine.sv
// Timing engine of the gate timer: prescaler, microsecond clock, holdoff, one-shot.
// Depends on tpcgt_pkg; the result is combinational for the tick being stepped.
`timescale 1ns / 1ps

module tpcgt_engine #(
   parameter int TICKS_PER_MICROSECOND         = tpcgt_pkg::DEF_US_TICKS,
   parameter int GATE_PULSE_MICROSECONDS       = tpcgt_pkg::DEF_PULSE_US,
   parameter int ZERO_CROSS_OFFSET_MICROSECONDS = tpcgt_pkg::DEF_ZC_OFFSET_US
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  zc_edge,
   input  tpcgt_pkg::cfg_type    cfg,
   output tpcgt_pkg::result_type result
);
   import tpcgt_pkg::*;

   localparam int PULSE_PROD = GATE_PULSE_MICROSECONDS * TICKS_PER_MICROSECOND;
   localparam logic [COUNT_W-1:0] PULSE_LOAD =
      ((PULSE_PROD % (2 ** COUNT_W)) == 0) ? COUNT_W'(1) : COUNT_W'(PULSE_PROD);

   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;
   logic [US_W-1:0]       clock_ff, clock_in;
   logic [US_W-1:0]       last_ff, last_in;
   logic                  last_valid_ff, last_valid_in;
   logic                  pending_ff, pending_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  running_ff, running_in;
   logic                  gate_ff, gate_in;

   logic [PRESCALE_W:0]   prescale_sum;
   logic                  prescale_wrap;
   logic [COUNT_W-1:0]    count_dec;
   logic [US_W-1:0]       delta;
   logic                  edge_pass;
   logic [BASE_W-1:0]     base;
   logic [CFG_W-1:0]      corr;
   logic [BASE_W-1:0]     load_raw;
   logic [COUNT_W-1:0]    load;

   // Advance the prescaler and the microsecond clock
   assign prescale_sum  = {1'b0, prescale_ff} + (PRESCALE_W + 1)'(1);
   assign prescale_wrap = prescale_sum >= (PRESCALE_W + 1)'(TICKS_PER_MICROSECOND);
   assign prescale_in   = prescale_wrap ? '0 : prescale_sum[PRESCALE_W-1:0];
   assign clock_in      = prescale_wrap ? clock_ff + US_W'(1) : clock_ff;

   // Holdoff check against the updated clock
   assign delta     = clock_in - last_ff;
   assign edge_pass = zc_edge &&
                      (!last_valid_ff || (delta > {{(US_W - CFG_W){1'b0}}, cfg.zc_holdoff_us}));

   // Load value: offset plus cut in ticks, less the raw drift correction
   assign base = BASE_W'(({{(BASE_W - CFG_W){1'b0}}, cfg.cut_delay_us} +
                          BASE_W'(ZERO_CROSS_OFFSET_MICROSECONDS)) *
                         BASE_W'(TICKS_PER_MICROSECOND));
   assign corr = (last_valid_ff && ({{(US_W - CFG_W){1'b0}}, cfg.half_cycle_us} > delta)) ?
                 cfg.half_cycle_us - delta[CFG_W-1:0] : '0;
   assign load_raw = ({{(BASE_W - CFG_W){1'b0}}, corr} >= base) ?
                     BASE_W'(1) : base - {{(BASE_W - CFG_W){1'b0}}, corr};
   assign load = (load_raw[COUNT_W-1:0] == '0) ? COUNT_W'(1) : load_raw[COUNT_W-1:0];

   assign count_dec = (count_ff != '0) ? count_ff - COUNT_W'(1) : count_ff;

   // One-shot first, then the edge decision overrides
   always_comb begin
      pending_in    = pending_ff;
      count_in      = count_ff;
      running_in    = running_ff;
      gate_in       = gate_ff;
      last_in       = last_ff;
      last_valid_in = last_valid_ff;
      if (running_ff) begin
         count_in = count_dec;
         if (count_dec == '0) begin
            if (pending_ff) begin
               gate_in    = 1'b1;
               pending_in = 1'b0;
               count_in   = PULSE_LOAD;
            end else begin
               gate_in    = 1'b0;
               running_in = 1'b0;
            end
         end
      end
      if (edge_pass) begin
         if (cfg.cut_delay_us >= cfg.max_cut_us) begin
            gate_in = 1'b0;
         end else if (cfg.cut_delay_us <= cfg.min_cut_us) begin
            gate_in = 1'b1;
         end else begin
            pending_in = 1'b1;
            count_in   = load;
            running_in = 1'b1;
         end
         last_in       = clock_in;
         last_valid_in = 1'b1;
      end
   end

   // Commit the state once per stepped tick
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff   <= '0;
         clock_ff      <= '0;
         last_ff       <= '0;
         last_valid_ff <= 1'b0;
         pending_ff    <= 1'b0;
         count_ff      <= '0;
         running_ff    <= 1'b0;
         gate_ff       <= 1'b0;
      end else if (step) begin
         prescale_ff   <= prescale_in;
         clock_ff      <= clock_in;
         last_ff       <= last_in;
         last_valid_ff <= last_valid_in;
         pending_ff    <= pending_in;
         count_ff      <= count_in;
         running_ff    <= running_in;
         gate_ff       <= gate_in;
      end
   end

   assign result.gate_on     = gate_in;
   assign result.zc_accepted = edge_pass;

endmodule

FILE: rtl/tpcgt_checker.sv
// Port-level checker of the gate timer and its bind to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpcgt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_gate_on,
   input logic rsp_zc_accepted,
   input logic csr_ready
);

   // Drop no result word while the sink stalls
   `TPCGT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_gate_on) && $stable(rsp_zc_accepted))

   // A fresh result follows a tick accepted through the input register
   `TPCGT_ASSERT_IMP(a_rsp_latency, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2))

   // A ready sink never stalls the request side
   `TPCGT_ASSERT_IMP(a_req_ready, clock, reset, rsp_ready, req_ready && csr_ready)

   // Leave reset with an empty output register
   `TPCGT_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind triac_phase_cut_gate_timer_top tpcgt_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_gate_on     (rsp_chan.gate_on),
   .rsp_zc_accepted (rsp_chan.zc_accepted),
   .csr_ready       (csr_chan.ready)
);
